[sv/framebuffer_column_draw_dirty_pages_defines.svh]
// Assertion macros shared by the frame store checker.
`ifndef FRAMEBUFFER_COLUMN_DRAW_DIRTY_PAGES_DEFINES_SVH
`define FRAMEBUFFER_COLUMN_DRAW_DIRTY_PAGES_DEFINES_SVH

// Implication checked at the same edge, switched off while reset is high.
`define FCDP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked at the following edge, active during reset as well.
`define FCDP_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/fcdp_pkg.sv]
// Types and constants of the column frame store with per-page dirty marks.
package fcdp_pkg;

   localparam int WIDTH_DEF = 128;
   localparam int PAGES_DEF = 4;
   localparam int MAX_ROWS  = 64;
   localparam int MAX_PAGES = 8;

   localparam logic KIND_DRAW  = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   localparam logic [1:0] OP_REPLACE = 2'd0;
   localparam logic [1:0] OP_SET     = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [7:0]  column;
      logic [7:0]  row;
      logic [7:0]  length;
      logic [31:0] pixel_bits;
      logic [1:0]  op;
      logic [3:0]  clear_mask;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] column_data;
      logic [3:0]  dirty_pages;
   } rsp_type;

   // Column write-back, sized for the largest store.
   typedef struct packed {
      logic                 we;
      logic [MAX_ROWS-1:0]  pix;
      logic [MAX_PAGES-1:0] dirty;
   } upd_type;

endpackage

[sv/fcdp_col_update.sv]
// Merge of one item into its column: run masking, page compare, result fields.
module fcdp_col_update #(
   parameter int WIDTH = fcdp_pkg::WIDTH_DEF,
   parameter int PAGES = fcdp_pkg::PAGES_DEF
) (
   input  fcdp_pkg::req_type                req,
   input  logic [fcdp_pkg::MAX_ROWS-1:0]    old_pix,
   input  logic [fcdp_pkg::MAX_PAGES-1:0]   old_dirty,
   output fcdp_pkg::upd_type                upd,
   output fcdp_pkg::rsp_type                rsp
);

   localparam int ROWS = PAGES * 8;
   localparam logic [fcdp_pkg::MAX_ROWS-1:0] ROW_MASK =
      (ROWS >= fcdp_pkg::MAX_ROWS) ? {fcdp_pkg::MAX_ROWS{1'b1}}
                                   : ((64'd1 << ROWS) - 64'd1);
   localparam logic [fcdp_pkg::MAX_PAGES-1:0] PAGE_MASK =
      (PAGES >= fcdp_pkg::MAX_PAGES) ? {fcdp_pkg::MAX_PAGES{1'b1}}
                                     : 8'((9'd1 << PAGES) - 9'd1);

   logic                             col_err;
   logic                             run_err;
   logic [fcdp_pkg::MAX_ROWS-1:0]    len_mask;
   logic [fcdp_pkg::MAX_ROWS-1:0]    run_mask;
   logic [fcdp_pkg::MAX_ROWS-1:0]    src;
   logic [fcdp_pkg::MAX_ROWS-1:0]    new_pix;
   logic [fcdp_pkg::MAX_PAGES-1:0]   changed;
   logic [fcdp_pkg::MAX_PAGES-1:0]   new_dirty;
   logic                             draw_we;

   assign col_err = {1'b0, req.column} >= 9'(WIDTH);
   assign run_err = ({1'b0, req.row} + {1'b0, req.length}) > 9'(ROWS);

   // Run mask of length low ones, shifted to the start row
   assign len_mask = (req.length >= 8'd64) ? {fcdp_pkg::MAX_ROWS{1'b1}}
                   : ((64'd1 << req.length[5:0]) - 64'd1);
   assign run_mask = len_mask << req.row[5:0];
   assign src      = ({32'd0, req.pixel_bits} & len_mask) << req.row[5:0];

   always_comb begin
      case (req.op)
         fcdp_pkg::OP_REPLACE: new_pix = (old_pix & ~run_mask) | src;
         fcdp_pkg::OP_SET:     new_pix = old_pix | src;
         fcdp_pkg::OP_CLEAR:   new_pix = old_pix & ~src;
         default:              new_pix = old_pix;
      endcase
      new_pix = new_pix & ROW_MASK;
   end

   // Mark each page byte that differs
   always_comb begin
      for (int p = 0; p < fcdp_pkg::MAX_PAGES; p++) begin
         changed[p] = (old_pix[8*p +: 8] != new_pix[8*p +: 8]);
      end
   end

   assign new_dirty = (old_dirty | changed) & PAGE_MASK;
   assign draw_we   = (req.length != 8'd0) && (req.op != fcdp_pkg::OP_NONE);

   always_comb begin
      upd.we    = 1'b0;
      upd.pix   = old_pix;
      upd.dirty = old_dirty;
      rsp.status      = fcdp_pkg::STATUS_OK;
      rsp.column_data = old_pix[31:0];
      rsp.dirty_pages = old_dirty[3:0];
      if (col_err) begin
         rsp.status      = fcdp_pkg::STATUS_ERR;
         rsp.column_data = '0;
         rsp.dirty_pages = '0;
      end else if (req.kind == fcdp_pkg::KIND_FETCH) begin
         // Report marks before clearing the selected ones
         upd.we    = 1'b1;
         upd.dirty = old_dirty & ~{4'd0, req.clear_mask} & PAGE_MASK;
      end else if (run_err) begin
         rsp.status      = fcdp_pkg::STATUS_ERR;
         rsp.column_data = '0;
         rsp.dirty_pages = '0;
      end else if (draw_we) begin
         upd.we    = 1'b1;
         upd.pix   = new_pix;
         upd.dirty = new_dirty;
         rsp.column_data = new_pix[31:0];
         rsp.dirty_pages = new_dirty[3:0];
      end
   end

endmodule

[sv/framebuffer_column_draw_dirty_pages.sv]
// Top level of the column frame store with per-page dirty marks.
//
// Channels: an item on req_data is taken at a clock edge where start is high
// and busy is low; busy stays low, so an item may be given in every cycle.
// A draw item writes a run of pixels into one column (replace, set or clear)
// and marks every page byte it changes; a fetch item reports the column and
// its marks, then clears the marks picked by clear_mask.
// Each item yields one result on rsp_data, shown for one cycle with
// rsp_valid high: the accepting edge loads the item and reads the column
// memory, the next edge loads the result register and writes the column
// back. Throughput is one item per cycle; a back-to-back item on the same
// column takes the fresh column from a write-back bypass register.
// Reset clears the per-column valid bits at once, so every column reads as
// blank and clean straight away; no clearing pass is needed.
// The receiver cannot stall: each result must be taken in its cycle.
module framebuffer_column_draw_dirty_pages #(
   parameter int WIDTH = fcdp_pkg::WIDTH_DEF,
   parameter int PAGES = fcdp_pkg::PAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fcdp_pkg::req_type req_data,
   output logic              rsp_valid,
   output fcdp_pkg::rsp_type rsp_data
);

   localparam int ROWS  = PAGES * 8;
   localparam int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [ROWS-1:0]  pix_mem [WIDTH];
   logic [PAGES-1:0] dirty_mem [WIDTH];

   logic [WIDTH-1:0]  valid_ff;
   logic              req_vld_ff;
   fcdp_pkg::req_type req_ff;
   logic [ROWS-1:0]   rd_pix_ff;
   logic [PAGES-1:0]  rd_dirty_ff;
   logic              rd_vld_ff;
   logic              wr_en_ff;
   logic [IDX_W-1:0]  wr_idx_ff;
   logic [ROWS-1:0]   wr_pix_ff;
   logic [PAGES-1:0]  wr_dirty_ff;
   logic              rsp_valid_ff;
   fcdp_pkg::rsp_type rsp_ff;

   logic                              accept;
   logic [IDX_W-1:0]                  in_idx;
   logic [IDX_W-1:0]                  cur_idx;
   logic [fcdp_pkg::MAX_ROWS-1:0]     cur_pix;
   logic [fcdp_pkg::MAX_PAGES-1:0]    cur_dirty;
   fcdp_pkg::upd_type                 upd;
   fcdp_pkg::rsp_type                 rsp_in;
   logic                              wr_en;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign in_idx  = req_data.column[IDX_W-1:0];
   assign cur_idx = req_ff.column[IDX_W-1:0];

   // Take the last write-back first, then memory, else a blank column
   always_comb begin
      cur_pix   = '0;
      cur_dirty = '0;
      if (wr_en_ff && (wr_idx_ff == cur_idx)) begin
         cur_pix[ROWS-1:0]    = wr_pix_ff;
         cur_dirty[PAGES-1:0] = wr_dirty_ff;
      end else if (rd_vld_ff) begin
         cur_pix[ROWS-1:0]    = rd_pix_ff;
         cur_dirty[PAGES-1:0] = rd_dirty_ff;
      end
   end

   fcdp_col_update #(
      .WIDTH (WIDTH),
      .PAGES (PAGES)
   ) u_update (
      .req       (req_ff),
      .old_pix   (cur_pix),
      .old_dirty (cur_dirty),
      .upd       (upd),
      .rsp       (rsp_in)
   );

   assign wr_en = req_vld_ff && upd.we;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_pix_ff   <= pix_mem[in_idx];
         rd_dirty_ff <= dirty_mem[in_idx];
      end
      if (wr_en) begin
         pix_mem[cur_idx]   <= upd.pix[ROWS-1:0];
         dirty_mem[cur_idx] <= upd.dirty[PAGES-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         req_vld_ff   <= 1'b0;
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[cur_idx] <= 1'b1;
         end
         req_vld_ff   <= accept;
         wr_en_ff     <= wr_en;
         rsp_valid_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff    <= req_data;
         rd_vld_ff <= valid_ff[in_idx];
      end
      wr_idx_ff   <= cur_idx;
      wr_pix_ff   <= upd.pix[ROWS-1:0];
      wr_dirty_ff <= upd.dirty[PAGES-1:0];
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/fcdp_checker.sv]
// Port-level checks of the column frame store, bound to the top level.
`include "framebuffer_column_draw_dirty_pages_defines.svh"

module fcdp_checker #(
   parameter int WIDTH = fcdp_pkg::WIDTH_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input fcdp_pkg::req_type req_data,
   input logic              rsp_valid,
   input fcdp_pkg::rsp_type rsp_data
);

   `FCDP_ASSERT_IMP(a_result_follows, clock, reset, start && !busy, ##2 rsp_valid, "item without result")
   `FCDP_ASSERT_IMP(a_no_stray_result, clock, reset, rsp_valid, $past(start && !busy, 2), "result without item")
   `FCDP_ASSERT_IMP(a_error_blank, clock, reset, rsp_valid && (rsp_data.status == fcdp_pkg::STATUS_ERR), (rsp_data.column_data == 32'd0) && (rsp_data.dirty_pages == 4'd0), "error result carries data")
   `FCDP_ASSERT_IMP(a_bad_column, clock, reset, start && !busy && ({1'b0, req_data.column} >= 9'(WIDTH)), ##2 (rsp_data.status == fcdp_pkg::STATUS_ERR), "bad column not flagged")
   `FCDP_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_valid, "result during reset")

endmodule

bind framebuffer_column_draw_dirty_pages fcdp_checker #(.WIDTH(WIDTH)) u_fcdp_checker (.*);

[verif/tb_framebuffer_column_draw_dirty_pages.sv]
// Testbench of the column frame store: draws, fetches and range errors against a predicted store.
module tb_framebuffer_column_draw_dirty_pages;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS     = fcdp_pkg::WIDTH_DEF;
   localparam int PAGE_COUNT  = fcdp_pkg::PAGES_DEF;
   localparam int ROW_COUNT   = fcdp_pkg::PAGES_DEF * 8;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   fcdp_pkg::req_type req_data;
   logic              rsp_valid;
   fcdp_pkg::rsp_type rsp_data;

   // Predicted store contents.
   logic [31:0] column_pixels [COLUMNS];
   logic [3:0]  column_dirty  [COLUMNS];

   fcdp_pkg::rsp_type expected_results [$];

   int unsigned items_sent;
   int unsigned results_checked;
   int unsigned fetches_sent;
   int unsigned error_results;
   int unsigned mismatches;

   framebuffer_column_draw_dirty_pages i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
               expected_results.size());
      $display("FAIL");
      $finish;
   end

   // Work out the result of one item and advance the predicted store.
   function automatic fcdp_pkg::rsp_type predict_result(input fcdp_pkg::req_type item);
      fcdp_pkg::rsp_type res;
      logic [63:0]       run_mask;
      logic [63:0]       run_bits;
      logic [31:0]       old_col;
      logic [31:0]       new_col;
      logic [3:0]        marks;
      int                col;

      res = '0;
      col = item.column;
      if (col >= COLUMNS) begin
         res.status = fcdp_pkg::STATUS_ERR;
         return res;
      end
      if (item.kind == fcdp_pkg::KIND_FETCH) begin
         marks = column_dirty[col];
         res.status      = fcdp_pkg::STATUS_OK;
         res.column_data = column_pixels[col];
         res.dirty_pages = marks;
         column_dirty[col] = marks & ~item.clear_mask;
         return res;
      end
      if (int'(item.row) + int'(item.length) > ROW_COUNT) begin
         res.status = fcdp_pkg::STATUS_ERR;
         return res;
      end
      if (item.length != 0 && item.op != fcdp_pkg::OP_NONE) begin
         old_col  = column_pixels[col];
         run_mask = ((64'd1 << item.length) - 64'd1);
         run_bits = ({32'd0, item.pixel_bits} & run_mask) << item.row;
         run_mask = run_mask << item.row;
         case (item.op)
            fcdp_pkg::OP_REPLACE: new_col = (old_col & ~run_mask[31:0]) | run_bits[31:0];
            fcdp_pkg::OP_SET:     new_col = old_col | run_bits[31:0];
            default:              new_col = old_col & ~run_bits[31:0];
         endcase
         for (int p = 0; p < PAGE_COUNT; p++) begin
            if (old_col[8*p +: 8] != new_col[8*p +: 8]) column_dirty[col][p] = 1'b1;
         end
         column_pixels[col] = new_col;
      end
      res.status      = fcdp_pkg::STATUS_OK;
      res.column_data = column_pixels[col];
      res.dirty_pages = column_dirty[col];
      return res;
   endfunction

   function automatic fcdp_pkg::req_type build_item(input logic kind, input int column,
                                                    input int row, input int length,
                                                    input logic [31:0] bits,
                                                    input logic [1:0] op,
                                                    input logic [3:0] mask);
      fcdp_pkg::req_type item;
      item.kind       = kind;
      item.column     = column[7:0];
      item.row        = row[7:0];
      item.length     = length[7:0];
      item.pixel_bits = bits;
      item.op         = op;
      item.clear_mask = mask;
      return item;
   endfunction

   task automatic send_item(input fcdp_pkg::req_type item, input int unsigned gap);
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start    = 1'b1;
      req_data = item;
      do @(posedge clock); while (busy);
      expected_results.push_back(predict_result(item));
      items_sent++;
      if (item.kind == fcdp_pkg::KIND_FETCH) fetches_sent++;
   endtask

   // Drop start and hold off until every expected result has come.
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      fcdp_pkg::rsp_type exp_res;
      if (!reset && rsp_valid) begin
         results_checked++;
         if (rsp_data.status == fcdp_pkg::STATUS_ERR) error_results++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Unexpected result: status %0d data %08h dirty %h",
                        rsp_data.status, rsp_data.column_data, rsp_data.dirty_pages);
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_data.status !== exp_res.status ||
                rsp_data.column_data !== exp_res.column_data ||
                rsp_data.dirty_pages !== exp_res.dirty_pages) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("Mismatch on result %0d: status %0d/%0d data %08h/%08h dirty %h/%h",
                           results_checked, exp_res.status, rsp_data.status,
                           exp_res.column_data, rsp_data.column_data,
                           exp_res.dirty_pages, rsp_data.dirty_pages);
            end
         end
      end
   end

   task automatic test_blank_after_reset();
      send_item(build_item(fcdp_pkg::KIND_FETCH, 0, 0, 0, 32'h0, fcdp_pkg::OP_REPLACE, 4'h0),
                0);
      send_item(build_item(fcdp_pkg::KIND_FETCH, COLUMNS - 1, 0, 0, 32'h0,
                           fcdp_pkg::OP_REPLACE, 4'hF), 1);
   endtask

   task automatic test_draw_operations();
      send_item(build_item(fcdp_pkg::KIND_DRAW, 5, 0, 32, 32'hFFFF_FFFF,
                           fcdp_pkg::OP_REPLACE, 4'h0), 0);
      send_item(build_item(fcdp_pkg::KIND_DRAW, 5, 8, 8, 32'hFF, fcdp_pkg::OP_CLEAR, 4'h0), 2);
      send_item(build_item(fcdp_pkg::KIND_DRAW, 5, 10, 3, 32'h5, fcdp_pkg::OP_SET, 4'h0), 0);
      // Rewriting identical pixels leaves the marks alone.
      send_item(build_item(fcdp_pkg::KIND_DRAW, 6, 0, 8, 32'h0, fcdp_pkg::OP_REPLACE, 4'h0), 0);
      send_item(build_item(fcdp_pkg::KIND_DRAW, 5, 0, 32, 32'h0, fcdp_pkg::OP_NONE, 4'h0), 3);
      send_item(build_item(fcdp_pkg::KIND_DRAW, 5, 4, 0, 32'hFFFF_FFFF,
                           fcdp_pkg::OP_REPLACE, 4'h0), 0);
      send_item(build_item(fcdp_pkg::KIND_FETCH, 5, 0, 0, 32'h0, fcdp_pkg::OP_REPLACE,
                           4'b0101), 0);
      send_item(build_item(fcdp_pkg::KIND_FETCH, 5, 0, 0, 32'h0, fcdp_pkg::OP_REPLACE, 4'hF),
                1);
      send_item(build_item(fcdp_pkg::KIND_FETCH, 5, 0, 0, 32'h0, fcdp_pkg::OP_REPLACE, 4'h0),
                0);
   endtask

   task automatic test_range_errors();
      send_item(build_item(fcdp_pkg::KIND_DRAW, COLUMNS, 0, 1, 32'h1, fcdp_pkg::OP_SET, 4'h0),
                0);
      send_item(build_item(fcdp_pkg::KIND_DRAW, 255, 255, 255, 32'hFFFF_FFFF,
                           fcdp_pkg::OP_NONE, 4'hF), 0);
      send_item(build_item(fcdp_pkg::KIND_FETCH, 200, 0, 0, 32'h0, fcdp_pkg::OP_REPLACE, 4'hF),
                1);
      send_item(build_item(fcdp_pkg::KIND_DRAW, 7, 24, 9, 32'h1FF, fcdp_pkg::OP_REPLACE, 4'h0),
                0);
      send_item(build_item(fcdp_pkg::KIND_DRAW, 7, 255, 255, 32'hFFFF_FFFF,
                           fcdp_pkg::OP_SET, 4'h0), 0);
      send_item(build_item(fcdp_pkg::KIND_DRAW, COLUMNS - 1, ROW_COUNT - 1, 1, 32'h1,
                           fcdp_pkg::OP_SET, 4'h0), 2);
      send_item(build_item(fcdp_pkg::KIND_DRAW, COLUMNS - 1, ROW_COUNT, 0, 32'h0,
                           fcdp_pkg::OP_REPLACE, 4'h0), 0);
   endtask

   // Same column on consecutive cycles, through the write-back bypass.
   task automatic test_back_to_back();
      send_item(build_item(fcdp_pkg::KIND_DRAW, 9, 3, 20, 32'hA5A5_5A5A,
                           fcdp_pkg::OP_REPLACE, 4'h0), 0);
      send_item(build_item(fcdp_pkg::KIND_DRAW, 9, 16, 16, 32'hF0F0, fcdp_pkg::OP_SET, 4'h0),
                0);
      send_item(build_item(fcdp_pkg::KIND_DRAW, 9, 0, 12, 32'hFFF, fcdp_pkg::OP_CLEAR, 4'h0),
                0);
      send_item(build_item(fcdp_pkg::KIND_FETCH, 9, 0, 0, 32'h0, fcdp_pkg::OP_REPLACE,
                           4'b1010), 0);
   endtask

   function automatic fcdp_pkg::req_type random_item();
      fcdp_pkg::req_type item;
      logic [63:0]       noise;
      int                row;
      noise = {$urandom, $urandom};
      item = noise[$bits(fcdp_pkg::req_type)-1:0];
      if ($urandom_range(0, 9) == 0) return item;  // noise: any field value
      item.column = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3))
                                                : 8'($urandom_range(0, COLUMNS - 1));
      item.kind = ($urandom_range(0, 3) == 0) ? fcdp_pkg::KIND_FETCH : fcdp_pkg::KIND_DRAW;
      row = $urandom_range(0, ROW_COUNT - 1);
      item.row = 8'(row);
      item.length = 8'($urandom_range(0, ROW_COUNT - row));
      item.op = ($urandom_range(0, 19) == 0) ? fcdp_pkg::OP_NONE
                                             : 2'($urandom_range(0, 2));
      return item;
   endfunction

   task automatic test_random_traffic();
      bit burst;
      burst = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) burst = ($urandom_range(0, 2) == 0);
         if (n == RANDOM_ITEMS / 2) wait_drained();
         send_item(random_item(), burst ? 0 : $urandom_range(0, 8));
      end
   endtask

   initial begin
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      items_sent = 0;
      results_checked = 0;
      fetches_sent = 0;
      error_results = 0;
      mismatches = 0;
      for (int c = 0; c < COLUMNS; c++) begin
         column_pixels[c] = '0;
         column_dirty[c]  = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_blank_after_reset();
      test_draw_operations();
      test_range_errors();
      test_back_to_back();
      test_random_traffic();
      wait_drained();
      repeat (10) @(posedge clock);

      if (expected_results.size() != 0) mismatches += expected_results.size();
      $display("Sent %0d items (%0d fetches), checked %0d results, %0d with error status",
               items_sent, fetches_sent, results_checked, error_results);
      $display("Mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/fcdp_pkg.sv
sv/fcdp_col_update.sv
sv/framebuffer_column_draw_dirty_pages.sv
sv/fcdp_checker.sv
verif/tb_framebuffer_column_draw_dirty_pages.sv
